// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of aclk, skipped while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check an implication whose consequent is checked in the cycle after the antecedent, skipped while reset is held.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hw/rtl/mct_pkg.sv -----
package mct_pkg;

    // Default sizes of the chain and the tables
    localparam int MAX_CAMERAS_DEF  = 8;
    localparam int MAX_FEATURES_DEF = 2048;
    localparam int MAX_TRACKS_DEF   = 4096;

    // Fixed field widths
    localparam int PAIR_W      = 3;
    localparam int FEAT_W      = 11;
    localparam int TRACK_OUT_W = 12;
    localparam int CAM_W       = 3;
    localparam int CFG_W       = 4;
    localparam int TDATA_W     = 32;
    localparam int M_TUSER_W   = 2;

    localparam logic [CFG_W-1:0] ACTIVE_CAMERAS_RESET = 4'd2;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic {
        OP_LINK  = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [PAIR_W-1:0]  pair;
        logic [FEAT_W-1:0]  first_index;
        logic [FEAT_W-1:0]  second_index;
    } queue_entry_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// ----- hw/rtl/mct_ram.sv -----
module mct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, and a registered read that holds while re is low
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/mct_queue.sv -----
`include "assert_macros.svh"

module mct_queue
    import mct_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output queue_entry_t head_entry,
    output logic         empty,
    output logic         full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t            slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign empty      = (count_reg == '0);
    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_entry = slots_reg[rd_ptr_reg];

    // Store the entry at the tail
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_CLK(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `ASSERT_NEXT(a_count_push, do_push && !do_pop, count_reg == $past(count_reg) + CNT_W'(1), "queue count missed a push")

endmodule

// ----- hw/rtl/mct_front.sv -----
module mct_front
    import mct_pkg::*;
#(
    parameter int MAX_CAMERAS  = MAX_CAMERAS_DEF,
    parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,    // pair, first_index, second_index
    input  logic               s_tuser,    // kind
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data,   // active_cameras
    input  back_status_t       status,
    input  logic               q_full,
    output logic               push,
    output queue_entry_t       push_entry
);

    logic [CFG_W-1:0]  active_cameras_reg;
    logic [PAIR_W-1:0] pair;
    logic [FEAT_W-1:0] first_index;
    logic [FEAT_W-1:0] second_index;
    logic              in_transfer;
    logic              pair_out;
    logic              index_out;

    assign pair         = s_tdata[PAIR_W-1:0];
    assign first_index  = s_tdata[PAIR_W+FEAT_W-1:PAIR_W];
    assign second_index = s_tdata[PAIR_W+2*FEAT_W-1:PAIR_W+FEAT_W];

    // Hold off the input while the queue is full or the store is being wiped
    assign s_tready    = !q_full && !status.clearing;
    assign in_transfer = s_tvalid && s_tready;
    assign cfg_ready   = 1'b1;

    // Hold the chain length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_cameras_reg <= ACTIVE_CAMERAS_RESET;
        end else if (cfg_valid) begin
            active_cameras_reg <= cfg_data;
        end
    end

    // Classify: drop matches beyond the chain or outside the feature range
    assign pair_out  = (({1'b0, pair} + 4'd1) >= active_cameras_reg)
                    || ((32'(pair) + 32'd1) >= 32'(MAX_CAMERAS));
    assign index_out = (32'(first_index) >= 32'(MAX_FEATURES))
                    || (32'(second_index) >= 32'(MAX_FEATURES));

    always_comb begin
        push_entry.op           = s_tuser ? OP_CLEAR : OP_LINK;
        push_entry.pair         = pair;
        push_entry.first_index  = first_index;
        push_entry.second_index = second_index;
        push = in_transfer && (s_tuser || (!pair_out && !index_out));
    end

endmodule

// ----- hw/rtl/mct_back.sv -----
`include "assert_macros.svh"

module mct_back
    import mct_pkg::*;
#(
    parameter int MAX_CAMERAS  = MAX_CAMERAS_DEF,
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int MAX_TRACKS   = MAX_TRACKS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  queue_entry_t           head_entry,
    input  logic                   q_empty,
    output logic                   q_pop,
    output back_status_t           status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,   // track_id, camera, feature_index
    output logic [M_TUSER_W-1:0]   m_tuser,   // track_is_new, overflow
    output logic                   m_tlast
);

    localparam int DEPTH   = MAX_CAMERAS * MAX_FEATURES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ID_W    = $clog2(MAX_TRACKS);
    localparam int CNT_W   = $clog2(MAX_TRACKS + 1);
    localparam int ENTRY_W = ID_W + 1;
    localparam int PAD_W   = TDATA_W - TRACK_OUT_W - CAM_W - FEAT_W;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_DECIDE,
        B_SECOND
    } state_t;

    state_t                 state_reg;
    logic [ADDR_W-1:0]      clr_addr_reg;
    logic [CNT_W-1:0]       track_counter_reg;
    logic [ID_W-1:0]        id_reg;
    logic [PAIR_W-1:0]      cur_pair_reg;
    logic [FEAT_W-1:0]      cur_first_reg;
    logic [FEAT_W-1:0]      cur_second_reg;
    logic [ADDR_W-1:0]      addr_a_reg;
    logic [ADDR_W-1:0]      addr_b_reg;

    logic                   m_valid_reg;
    logic [TRACK_OUT_W-1:0] m_track_reg;
    logic [CAM_W-1:0]       m_cam_reg;
    logic [FEAT_W-1:0]      m_feat_reg;
    logic                   m_new_reg;
    logic                   m_last_reg;
    logic                   m_ovf_reg;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [31:0]            head_a_full;
    logic [31:0]            head_b_full;
    logic                   out_free;
    logic                   m_load;
    logic                   rd_valid;
    logic [ID_W-1:0]        rd_id;
    logic [ID_W-1:0]        new_id;
    logic                   table_full;
    logic [CAM_W-1:0]       cam_b;

    function automatic logic [TRACK_OUT_W-1:0] to_out_id(input logic [ID_W-1:0] id);
        logic [ID_W+TRACK_OUT_W-1:0] wide;
        wide = {{TRACK_OUT_W{1'b0}}, id};
        return wide[TRACK_OUT_W-1:0];
    endfunction

    mct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_owner_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_a_full[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Store addresses of both features of the head match
    assign head_a_full = 32'(head_entry.pair) * 32'(MAX_FEATURES) + 32'(head_entry.first_index);
    assign head_b_full = (32'(head_entry.pair) + 32'd1) * 32'(MAX_FEATURES)
                       + 32'(head_entry.second_index);

    assign out_free   = !m_valid_reg || m_tready;
    assign m_load     = out_free && ((state_reg == B_DECIDE) || (state_reg == B_SECOND));
    assign rd_valid   = ram_rdata[ID_W];
    assign rd_id      = ram_rdata[ID_W-1:0];
    assign new_id     = track_counter_reg[ID_W-1:0];
    assign table_full = (track_counter_reg == CNT_W'(MAX_TRACKS));
    assign cam_b      = cur_pair_reg + 3'd1;

    assign status.clearing = (state_reg == B_CLEAR);

    // Store port, queue pop and read issue
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_b_reg;
        ram_wdata = {1'b1, rd_id};
        ram_re    = 1'b0;
        q_pop     = 1'b0;
        case (state_reg)
            B_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            B_IDLE: begin
                q_pop  = !q_empty;
                ram_re = !q_empty && (head_entry.op == OP_LINK);
            end
            B_DECIDE: begin
                if (out_free) begin
                    if (rd_valid) begin
                        ram_we = 1'b1;
                    end else if (!table_full) begin
                        ram_we    = 1'b1;
                        ram_waddr = addr_a_reg;
                        ram_wdata = {1'b1, new_id};
                    end
                end
            end
            B_SECOND: begin
                ram_we    = out_free;
                ram_wdata = {1'b1, id_reg};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequence each item and load the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= B_CLEAR;
            clr_addr_reg      <= '0;
            track_counter_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!q_empty) begin
                        if (head_entry.op == OP_CLEAR) begin
                            clr_addr_reg      <= '0;
                            track_counter_reg <= '0;
                            state_reg         <= B_CLEAR;
                        end else begin
                            cur_pair_reg   <= head_entry.pair;
                            cur_first_reg  <= head_entry.first_index;
                            cur_second_reg <= head_entry.second_index;
                            addr_a_reg     <= head_a_full[ADDR_W-1:0];
                            addr_b_reg     <= head_b_full[ADDR_W-1:0];
                            state_reg      <= B_DECIDE;
                        end
                    end
                end
                B_DECIDE: begin
                    if (out_free) begin
                        if (rd_valid) begin
                            m_track_reg <= to_out_id(rd_id);
                            m_cam_reg   <= cam_b;
                            m_feat_reg  <= cur_second_reg;
                            m_new_reg   <= 1'b0;
                            m_last_reg  <= 1'b1;
                            m_ovf_reg   <= 1'b0;
                            state_reg   <= B_IDLE;
                        end else if (table_full) begin
                            m_track_reg <= '0;
                            m_cam_reg   <= cur_pair_reg;
                            m_feat_reg  <= cur_first_reg;
                            m_new_reg   <= 1'b0;
                            m_last_reg  <= 1'b1;
                            m_ovf_reg   <= 1'b1;
                            state_reg   <= B_IDLE;
                        end else begin
                            id_reg            <= new_id;
                            track_counter_reg <= track_counter_reg + 1'b1;
                            m_track_reg       <= to_out_id(new_id);
                            m_cam_reg         <= cur_pair_reg;
                            m_feat_reg        <= cur_first_reg;
                            m_new_reg         <= 1'b1;
                            m_last_reg        <= 1'b0;
                            m_ovf_reg         <= 1'b0;
                            state_reg         <= B_SECOND;
                        end
                    end
                end
                B_SECOND: begin
                    if (out_free) begin
                        m_track_reg <= to_out_id(id_reg);
                        m_cam_reg   <= cam_b;
                        m_feat_reg  <= cur_second_reg;
                        m_new_reg   <= 1'b1;
                        m_last_reg  <= 1'b1;
                        m_ovf_reg   <= 1'b0;
                        state_reg   <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_feat_reg, m_cam_reg, m_track_reg};
    assign m_tuser  = {m_ovf_reg, m_new_reg};
    assign m_tlast  = m_last_reg;

    `ASSERT_CLK(a_idle_no_write, (state_reg == B_IDLE) |-> !ram_we, "store written while idle")
    `ASSERT_CLK(a_counter_bound, track_counter_reg <= CNT_W'(MAX_TRACKS),
                "track counter beyond table")
    `ASSERT_CLK(a_second_has_track, (state_reg == B_SECOND) |-> (track_counter_reg != '0),
                "second result without a track")
    `ASSERT_NEXT(a_clear_holds_input, state_reg == B_CLEAR, !q_pop || (state_reg != B_CLEAR),
                 "queue popped during wipe")

endmodule

// ----- hw/rtl/match_chain_track_linker.sv -----
// Match chain track linker.
// Input channel (s_): one transfer is a match (s_tuser = 0) naming a camera pair and a
// feature in each of the two cameras, or a frame marker (s_tuser = 1) that wipes the
// feature ownership store and restarts track numbering.
// Output channel (m_): one transfer is one feature added to a track; m_tlast marks the
// final result of a match, m_tuser flags a new track and a refused (table full) track.
// Configuration channel (cfg_): writes the number of active cameras; always ready.
// Matches beyond the chain or outside the feature range are taken and dropped.
// A four-entry queue parts the input side from the linking engine, so input keeps
// flowing while the engine waits for the output register to be taken.
// A match that joins an existing track takes the engine through B_IDLE and B_DECIDE, one
// that opens a track through B_SECOND as well, since the store read is registered and its
// write follows it; the engine pops the next match only back in B_IDLE. With an empty
// queue an input match passes the queue, the store read and the output register before
// m_tvalid rises. A frame marker wipes all MAX_CAMERAS * MAX_FEATURES store entries (16384
// at defaults), one entry a cycle. The same wipe runs after reset; s_tready stays low throughout it.
// When m_tready is low the engine holds its result; the queue then fills and s_tready
// drops once it is full.
module match_chain_track_linker
    import mct_pkg::*;
#(
    parameter int MAX_CAMERAS  = MAX_CAMERAS_DEF,
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int MAX_TRACKS   = MAX_TRACKS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // pair[2:0], first_index[13:3], second_index[24:14]
    input  logic                 s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // track_id[11:0], camera[14:12], feature_index[25:15]
    output logic [M_TUSER_W-1:0] m_tuser,   // track_is_new[0], overflow[1]
    output logic                 m_tlast,   // last
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data   // active_cameras
);

    back_status_t status;
    queue_entry_t push_entry;
    queue_entry_t head_entry;
    logic         push;
    logic         q_pop;
    logic         q_empty;
    logic         q_full;

    mct_front #(
        .MAX_CAMERAS  (MAX_CAMERAS),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .status     (status),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    mct_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .empty      (q_empty),
        .full       (q_full)
    );

    mct_back #(
        .MAX_CAMERAS  (MAX_CAMERAS),
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_TRACKS   (MAX_TRACKS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
